FILE: hw/rtl/bitmap_index_allocator_core_macros.svh
// Assertion macros for the bitmap index allocator.
// They expect clk_i and rst_ni to be in scope at the point of use.
`ifndef BITMAP_INDEX_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_INDEX_ALLOCATOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BIA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BIA_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: hw/rtl/bia_pkg.sv
// Shared constants, types and helpers of the bitmap index allocator.
// No dependencies; used by bia_ffs and bitmap_index_allocator_core.
package bia_pkg;

  localparam int unsigned ENTRY_COUNT = 65536;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned IDX_W       = 16;

  localparam int unsigned WORD_TOTAL = (ENTRY_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned BW         = $clog2(WORD_BITS);

  // Words are summarised in groups of GRP_SZ full flags.
  localparam int unsigned GRP_SZ  = 32;
  localparam int unsigned GRP_CNT = (WORD_TOTAL + GRP_SZ - 1) / GRP_SZ;
  localparam int unsigned GSW     = $clog2(GRP_SZ);
  localparam int unsigned GAW     = $clog2(GRP_CNT);
  localparam int unsigned WAW     = GAW + GSW;

  // A word is searched one byte lane at a time.
  localparam int unsigned LANE_BITS = 8;
  localparam int unsigned LANES     = WORD_BITS / LANE_BITS;
  localparam int unsigned LW        = $clog2(LANES);
  localparam int unsigned LBW       = $clog2(LANE_BITS);

  // Width of the shared find-first unit.
  localparam int unsigned FFS_W  = 32;
  localparam int unsigned FFS_IW = $clog2(FFS_W);

  localparam int unsigned LAST_LEFT = ENTRY_COUNT - (WORD_TOTAL - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] LAST_MASK =
    {WORD_BITS{1'b1}} >> (WORD_BITS - LAST_LEFT);

  typedef struct packed {
    logic              found;
    logic [FFS_IW-1:0] idx;
  } ffs_res_t;

  // Bits of a word that map onto real entries.
  function automatic logic [WORD_BITS-1:0] word_valid_mask(input logic [WAW-1:0] word);
    logic [WORD_BITS-1:0] mask;
    mask = {WORD_BITS{1'b1}};
    if (word == WAW'(WORD_TOTAL - 1)) begin
      mask = LAST_MASK;
    end
    return mask;
  endfunction

endpackage

FILE: hw/rtl/bia_ffs.sv
// Find-first-set unit shared by every search step of the allocator.
// Depends on bia_pkg.
module bia_ffs
  import bia_pkg::*;
(
  input  logic [FFS_W-1:0] vec_i,
  output ffs_res_t         res_o
);

  always_comb begin
    res_o.found = |vec_i;
    res_o.idx   = '0;
    for (int i = FFS_W - 1; i >= 0; i--) begin
      if (vec_i[i]) begin
        res_o.idx = FFS_IW'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/bitmap_index_allocator_core.sv
// Bitmap index allocator: first-free allocation and release of entry indices.
// Item channel in: req_type_i (0 allocate, 1 release) and release_index_i.
// Item channel out: ok_o and granted_index_o, one result for every input item.
// Both channels use valid/ready; an item moves when valid and ready are high.
// After reset the block writes zeros through every word of the bitmap memory
// (one word a cycle) with in_ready_o low; then every entry is free.
// A full flag per word, grouped 32 to a summary word, steers the search: an
// allocate steps through group pick, word pick, memory read, byte-lane pick,
// bit pick and write, and result; a release steps through read, modify-write
// and result, and a full table goes from the group pick straight to result.
// One shared 32-bit find-first unit does every search step, and the single
// memory port serialises read and write, so one item is worked on at a time.
// The result sits in an output register; the next item is accepted while it
// waits, but its own result is held back until the receiver has taken the
// previous one. A stalled receiver therefore stops the input once a second
// item has finished behind the one that waits.
`include "bitmap_index_allocator_core_macros.svh"

module bitmap_index_allocator_core
  import bia_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  logic [IDX_W-1:0] release_index_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             ok_o,
  output logic [IDX_W-1:0] granted_index_o
);

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_GRP   = 9'b000000100,
    S_WSEL  = 9'b000001000,
    S_RD    = 9'b000010000,
    S_BYTE  = 9'b000100000,
    S_BIT   = 9'b001000000,
    S_REL   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [WORD_BITS-1:0] mem [WORD_TOTAL];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 mem_we, mem_re;
  logic [WAW-1:0]       mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [GRP_CNT-1:0][GRP_SZ-1:0] full_q;
  logic [GRP_CNT-1:0][GRP_SZ-1:0] word_exist;
  logic [GRP_CNT-1:0]             grp_full;

  logic [WAW-1:0] clr_cnt_q;
  logic [GAW-1:0] grp_q, grp_d;
  logic [WAW-1:0] word_q, word_d;
  logic [LW-1:0]  byte_q, byte_d;
  logic [BW-1:0]  rel_bit_q, rel_bit_d;
  logic           rel_ok_q, rel_ok_d;
  logic           rel_q, rel_d;

  logic             res_ok_q, res_ok_d;
  logic [IDX_W-1:0] res_idx_q, res_idx_d;
  logic             out_valid_q;
  logic             out_ok_q;
  logic [IDX_W-1:0] out_idx_q;
  logic             out_load;

  logic                 full_set, full_clr;
  logic [FFS_W-1:0]     ffs_vec;
  ffs_res_t             ffs_res;
  logic [WORD_BITS-1:0] avail;
  logic [LANES-1:0]     lane_free;
  logic [LANE_BITS-1:0] lane_bits;
  logic [BW-1:0]        alloc_bit;
  logic [WORD_BITS-1:0] alloc_onehot;
  logic [WORD_BITS-1:0] rel_onehot;

  bia_ffs u_ffs (
    .vec_i (ffs_vec),
    .res_o (ffs_res)
  );

  // Words past the end of the table count as full in the summary.
  always_comb begin
    for (int g = 0; g < GRP_CNT; g++) begin
      for (int k = 0; k < GRP_SZ; k++) begin
        word_exist[g][k] = ((g * GRP_SZ + k) < WORD_TOTAL);
      end
      grp_full[g] = &(full_q[g] | ~word_exist[g]);
    end
  end

  always_comb begin
    avail = ~rdata_q & word_valid_mask(word_q);
    for (int l = 0; l < LANES; l++) begin
      lane_free[l] = |avail[l*LANE_BITS +: LANE_BITS];
    end
    lane_bits    = avail[byte_q*LANE_BITS +: LANE_BITS];
    alloc_bit    = {byte_q, ffs_res.idx[LBW-1:0]};
    alloc_onehot = WORD_BITS'(1) << alloc_bit;
    rel_onehot   = WORD_BITS'(1) << rel_bit_q;
  end

  always_comb begin
    case (state_q)
      S_GRP:   ffs_vec = FFS_W'(~grp_full);
      S_WSEL:  ffs_vec = FFS_W'(~full_q[grp_q] & word_exist[grp_q]);
      S_BYTE:  ffs_vec = FFS_W'(lane_free);
      S_BIT:   ffs_vec = FFS_W'(lane_bits);
      default: ffs_vec = '0;
    endcase
  end

  assign out_load   = (state_q == S_FIN) && (!out_valid_q || out_ready_i);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    grp_d     = grp_q;
    word_d    = word_q;
    byte_d    = byte_q;
    rel_bit_d = rel_bit_q;
    rel_ok_d  = rel_ok_q;
    res_ok_d  = res_ok_q;
    res_idx_d = res_idx_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = word_q;
    mem_wdata = '0;
    full_set  = 1'b0;
    full_clr  = 1'b0;
    case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_q;
        if (clr_cnt_q == WAW'(WORD_TOTAL - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i) begin
            word_d    = release_index_i[BW +: WAW];
            rel_bit_d = release_index_i[BW-1:0];
            rel_ok_d  = ({1'b0, release_index_i} < (IDX_W+1)'(ENTRY_COUNT));
            res_ok_d  = 1'b1;
            res_idx_d = release_index_i;
            state_d   = S_RD;
          end else begin
            state_d = S_GRP;
          end
        end
      end
      S_GRP: begin
        if (ffs_res.found) begin
          grp_d   = ffs_res.idx[GAW-1:0];
          state_d = S_WSEL;
        end else begin
          res_ok_d  = 1'b0;
          res_idx_d = '0;
          state_d   = S_FIN;
        end
      end
      S_WSEL: begin
        word_d  = {grp_q, ffs_res.idx[GSW-1:0]};
        state_d = S_RD;
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = rel_q ? S_REL : S_BYTE;
      end
      S_BYTE: begin
        byte_d  = ffs_res.idx[LW-1:0];
        state_d = S_BIT;
      end
      S_BIT: begin
        mem_we    = 1'b1;
        mem_wdata = rdata_q | alloc_onehot;
        full_set  = ((avail & ~alloc_onehot) == '0);
        res_ok_d  = 1'b1;
        res_idx_d = IDX_W'({word_q, alloc_bit});
        state_d   = S_FIN;
      end
      S_REL: begin
        mem_we    = rel_ok_q;
        mem_wdata = rdata_q & ~rel_onehot;
        full_clr  = rel_ok_q;
        state_d   = S_FIN;
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Release items are tracked by this flag so that the shared read step
  // knows which way to continue.
  always_comb begin
    rel_d = rel_q;
    if (state_q == S_IDLE && in_valid_i) begin
      rel_d = req_type_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      full_q      <= '0;
      out_valid_q <= 1'b0;
      rel_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      rel_q   <= rel_d;
      if (state_q == S_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + WAW'(1);
      end
      if (full_set) begin
        full_q[word_q[WAW-1:GSW]][word_q[GSW-1:0]] <= 1'b1;
      end else if (full_clr) begin
        full_q[word_q[WAW-1:GSW]][word_q[GSW-1:0]] <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q     <= grp_d;
    word_q    <= word_d;
    byte_q    <= byte_d;
    rel_bit_q <= rel_bit_d;
    rel_ok_q  <= rel_ok_d;
    res_ok_q  <= res_ok_d;
    res_idx_q <= res_idx_d;
    if (out_load) begin
      out_ok_q  <= res_ok_q;
      out_idx_q <= res_idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign ok_o            = out_ok_q;
  assign granted_index_o = out_idx_q;

  `BIA_ASSERT_IMP(a_wsel_finds_word, state_q == S_WSEL, ffs_res.found,
    "group summary points at a group with no free word")
  `BIA_ASSERT_IMP(a_bit_lane_free, state_q == S_BIT, lane_bits != '0,
    "selected byte lane holds no free entry")
  `BIA_ASSERT_NXT(a_release_clears_full, state_q == S_REL && rel_ok_q,
    !full_q[word_q[WAW-1:GSW]][word_q[GSW-1:0]],
    "released word still marked full")

endmodule
